@@ hdl/sha1b_pkg.sv @@
// Shared constants and helper functions for the SHA-1 byte stream hasher.
package sha1b_pkg;

    localparam int WORD_W     = 32;
    localparam int DIGEST_N   = 5;
    localparam int BLOCK_N    = 16;
    localparam int ROUND_N    = 80;

    localparam logic [7:0]  PAD_BYTE = 8'h80;

    localparam logic [31:0] K_R0 = 32'h5A827999;
    localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_R3 = 32'hCA62C1D6;

    typedef logic [WORD_W-1:0] word_t;

    // Initial chaining value, word by word
    function automatic word_t sha1b_iv(input logic [2:0] idx);
        word_t v;
        unique case (idx)
            3'd0:    v = 32'h67452301;
            3'd1:    v = 32'hefcdab89;
            3'd2:    v = 32'h98badcfe;
            3'd3:    v = 32'h10325476;
            3'd4:    v = 32'hc3d2e1f0;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Round constant for round 0..79
    function automatic word_t sha1b_k(input logic [6:0] rnd);
        word_t v;
        if (rnd < 7'd20)
            v = K_R0;
        else if (rnd < 7'd40)
            v = K_R1;
        else if (rnd < 7'd60)
            v = K_R2;
        else
            v = K_R3;
        return v;
    endfunction

    // Round mixing function for round 0..79
    function automatic word_t sha1b_f(input logic [6:0] rnd, input word_t b,
                                      input word_t c, input word_t d);
        word_t v;
        if (rnd < 7'd20)
            v = (b & c) | (~b & d);
        else if (rnd >= 7'd40 && rnd < 7'd60)
            v = (b & c) | (b & d) | (c & d);
        else
            v = b ^ c ^ d;
        return v;
    endfunction

endpackage

@@ hdl/sha1b_msg_if.sv @@
// Message byte channel: valid/ready handshake plus the byte payload.
interface sha1b_msg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output has_byte, output last_byte,
                    input ready);
    modport sink   (input valid, input data_byte, input has_byte, input last_byte,
                    output ready);
endinterface

@@ hdl/sha1b_digest_if.sv @@
// Digest channel: valid/ready handshake plus one digest word per request.
interface sha1b_digest_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        final_word;

    modport source (output valid, output digest_word, output word_index, output final_word,
                    input ready);
    modport sink   (input valid, input digest_word, input word_index, input final_word,
                    output ready);
endinterface

@@ hdl/sha1_byte_stream_hasher.sv @@
// SHA-1 hasher top level: byte packing, padding, round sequencer and digest output.
//
// Usage:
//   msg    - sink channel, one request per cycle at most. has_byte marks data_byte as part
//            of the message; last_byte ends the message (a byte on the same request is
//            hashed first). has_byte=0, last_byte=0 is an idle request and does nothing.
//   digest - source channel, five requests per message end: word_index 0..4, most
//            significant word first, final_word on word 4.
// Operation:
//   A message byte is taken only in the idle state. The byte that completes a 64-byte block
//   starts a compression: the chaining value is read from its RAM, then 80 rounds at one
//   per cycle (message words come from the block RAM for rounds 0..15 and from a 16-word
//   schedule window after that), then the sums are added and written back. A message end
//   adds padding writes, one or two compressions, and the digest word reads. No message
//   bytes are taken while a compression, padding or digest output is under way.
// Reset:
//   Clears the byte position and bit length and marks the chaining value as the initial
//   value; no RAM clearing pass is needed.
// Stall:
//   The digest words sit in an output register. While the receiver holds ready low the
//   next word waits in the chain RAM read register; after the last word is loaded the
//   block takes new message bytes even if that word is not yet taken.
module sha1_byte_stream_hasher (
    input  logic           clk,
    input  logic           rst_n,
    sha1b_msg_if.sink      msg,
    sha1b_digest_if.source digest
);
    import sha1b_pkg::*;

    // Sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOAD  = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_WB    = 3'd3;
    localparam logic [2:0] ST_PADF  = 3'd4;
    localparam logic [2:0] ST_PADW  = 3'd5;
    localparam logic [2:0] ST_DRD   = 3'd6;
    localparam logic [2:0] ST_DWAIT = 3'd7;

    // What follows a compression
    localparam logic [1:0] POST_IDLE   = 2'd0;
    localparam logic [1:0] POST_PAD    = 2'd1;
    localparam logic [1:0] POST_EXTRA  = 2'd2;
    localparam logic [1:0] POST_DIGEST = 2'd3;

    localparam logic [2:0] LAST_IDX  = 3'(DIGEST_N - 1);
    localparam logic [6:0] LAST_RND  = 7'(ROUND_N - 1);
    localparam logic [3:0] LEN_HI_W  = 4'd14;
    localparam logic [3:0] LEN_LO_W  = 4'd15;

    logic [2:0]  state_reg, state_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [6:0]  round_reg, round_next;
    logic [1:0]  post_reg, post_next;
    logic        fresh_reg, fresh_next;
    logic [5:0]  byte_pos_reg, byte_pos_next;
    logic [63:0] len_reg, len_next;
    word_t       acc_reg, acc_next;
    logic [3:0]  widx_reg, widx_next;
    logic        len_phase_reg, len_phase_next;
    word_t       a_reg, a_next, b_reg, b_next, c_reg, c_next, d_reg, d_next, e_reg, e_next;
    word_t       win_reg [BLOCK_N];
    word_t       win_next [BLOCK_N];
    logic        out_valid_reg, out_valid_next;
    word_t       out_word_reg, out_word_next;
    logic [2:0]  out_idx_reg, out_idx_next;
    logic        out_final_reg, out_final_next;

    // RAM ports
    logic        blk_wr_en;
    logic [3:0]  blk_wr_addr;
    word_t       blk_wr_data;
    logic        blk_rd_en;
    logic [3:0]  blk_rd_addr;
    word_t       blk_rd_data;
    logic        chain_wr_en;
    logic [2:0]  chain_wr_addr;
    word_t       chain_wr_data;
    logic        chain_rd_en;
    logic [2:0]  chain_rd_addr;
    word_t       chain_rd_raw;
    word_t       chain_rd;

    logic        msg_fire;
    logic        out_free;
    logic [2:0]  cnt_prev;
    word_t       acc_ins;
    word_t       pad_word;
    word_t       w_cur;
    word_t       w_exp;
    word_t       t_sum;

    sha1b_ram #(.WIDTH(WORD_W), .DEPTH(BLOCK_N)) u_block_ram (
        .clk     (clk),
        .wr_en   (blk_wr_en),
        .wr_addr (blk_wr_addr),
        .wr_data (blk_wr_data),
        .rd_en   (blk_rd_en),
        .rd_addr (blk_rd_addr),
        .rd_data (blk_rd_data)
    );

    sha1b_ram #(.WIDTH(WORD_W), .DEPTH(DIGEST_N)) u_chain_ram (
        .clk     (clk),
        .wr_en   (chain_wr_en),
        .wr_addr (chain_wr_addr),
        .wr_data (chain_wr_data),
        .rd_en   (chain_rd_en),
        .rd_addr (chain_rd_addr),
        .rd_data (chain_rd_raw)
    );

    assign msg.ready    = (state_reg == ST_IDLE);
    assign msg_fire     = msg.valid && msg.ready;
    assign out_free     = !out_valid_reg || digest.ready;
    assign cnt_prev     = cnt_reg - 3'd1;

    // Chain value read: the initial value stands in until the first write-back
    assign chain_rd = fresh_reg ? sha1b_iv(cnt_prev) : chain_rd_raw;

    // Byte insertion into the word being packed (slot 0 starts a new word)
    always_comb
    begin
        case (byte_pos_reg[1:0])
            2'd0:    acc_ins = {msg.data_byte, 24'h0};
            2'd1:    acc_ins = {acc_reg[31:24], msg.data_byte, 16'h0};
            2'd2:    acc_ins = {acc_reg[31:16], msg.data_byte, 8'h0};
            default: acc_ins = {acc_reg[31:8], msg.data_byte};
        endcase
    end

    // First padding word: bytes so far, then 0x80, then zeros
    always_comb
    begin
        case (byte_pos_reg[1:0])
            2'd0:    pad_word = {PAD_BYTE, 24'h0};
            2'd1:    pad_word = {acc_reg[31:24], PAD_BYTE, 16'h0};
            2'd2:    pad_word = {acc_reg[31:16], PAD_BYTE, 8'h0};
            default: pad_word = {acc_reg[31:8], PAD_BYTE};
        endcase
    end

    // Message schedule and round adder
    assign w_exp = {win_reg[13][30:0] ^ win_reg[8][30:0] ^ win_reg[2][30:0] ^ win_reg[0][30:0],
                    win_reg[13][31] ^ win_reg[8][31] ^ win_reg[2][31] ^ win_reg[0][31]};
    assign w_cur = (round_reg < 7'(BLOCK_N)) ? blk_rd_data : w_exp;
    assign t_sum = {a_reg[26:0], a_reg[31:27]} + sha1b_f(round_reg, b_reg, c_reg, d_reg)
                 + e_reg + sha1b_k(round_reg) + w_cur;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        round_next     = round_reg;
        post_next      = post_reg;
        fresh_next     = fresh_reg;
        byte_pos_next  = byte_pos_reg;
        len_next       = len_reg;
        acc_next       = acc_reg;
        widx_next      = widx_reg;
        len_phase_next = len_phase_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        d_next         = d_reg;
        e_next         = e_reg;
        for (int i = 0; i < BLOCK_N; i++)
        begin
            win_next[i] = win_reg[i];
        end
        out_valid_next = out_valid_reg && !digest.ready;
        out_word_next  = out_word_reg;
        out_idx_next   = out_idx_reg;
        out_final_next = out_final_reg;

        blk_wr_en      = 1'b0;
        blk_wr_addr    = byte_pos_reg[5:2];
        blk_wr_data    = acc_ins;
        blk_rd_en      = 1'b0;
        blk_rd_addr    = '0;
        chain_wr_en    = 1'b0;
        chain_wr_addr  = cnt_prev;
        chain_wr_data  = chain_rd + a_reg;
        chain_rd_en    = 1'b0;
        chain_rd_addr  = cnt_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (msg_fire)
                begin
                    if (msg.has_byte)
                    begin
                        acc_next      = acc_ins;
                        blk_wr_en     = (byte_pos_reg[1:0] == 2'd3);
                        len_next      = len_reg + 64'd8;
                        byte_pos_next = byte_pos_reg + 6'd1;
                    end
                    if (msg.has_byte && byte_pos_reg == 6'd63)
                    begin
                        state_next = ST_LOAD;
                        cnt_next   = '0;
                        post_next  = msg.last_byte ? POST_PAD : POST_IDLE;
                    end
                    else if (msg.last_byte)
                    begin
                        state_next = ST_PADF;
                    end
                end
            end

            ST_PADF:
            begin
                blk_wr_en   = 1'b1;
                blk_wr_addr = byte_pos_reg[5:2];
                blk_wr_data = pad_word;
                if (byte_pos_reg[5:2] == LEN_LO_W)
                begin
                    state_next = ST_LOAD;
                    cnt_next   = '0;
                    post_next  = POST_EXTRA;
                end
                else
                begin
                    state_next     = ST_PADW;
                    widx_next      = byte_pos_reg[5:2] + 4'd1;
                    len_phase_next = (byte_pos_reg[5:2] < LEN_HI_W);
                end
            end

            ST_PADW:
            begin
                blk_wr_en   = 1'b1;
                blk_wr_addr = widx_reg;
                if (len_phase_reg && widx_reg == LEN_HI_W)
                    blk_wr_data = len_reg[63:32];
                else if (len_phase_reg && widx_reg == LEN_LO_W)
                    blk_wr_data = len_reg[31:0];
                else
                    blk_wr_data = '0;
                widx_next = widx_reg + 4'd1;
                if (widx_reg == LEN_LO_W)
                begin
                    state_next = ST_LOAD;
                    cnt_next   = '0;
                    post_next  = len_phase_reg ? POST_DIGEST : POST_EXTRA;
                end
            end

            // Read the chaining value into the working registers
            ST_LOAD:
            begin
                chain_rd_en = (cnt_reg < 3'(DIGEST_N));
                if (cnt_reg != 3'd0)
                begin
                    a_next = b_reg;
                    b_next = c_reg;
                    c_next = d_reg;
                    d_next = e_reg;
                    e_next = chain_rd;
                end
                if (cnt_reg == 3'(DIGEST_N))
                begin
                    blk_rd_en   = 1'b1;
                    blk_rd_addr = '0;
                    state_next  = ST_ROUND;
                    round_next  = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end

            // One SHA-1 round per cycle
            ST_ROUND:
            begin
                blk_rd_en   = (round_reg < 7'(BLOCK_N - 1));
                blk_rd_addr = round_reg[3:0] + 4'd1;
                for (int i = 0; i < BLOCK_N - 1; i++)
                begin
                    win_next[i] = win_reg[i + 1];
                end
                win_next[BLOCK_N - 1] = w_cur;
                e_next = d_reg;
                d_next = c_reg;
                c_next = {b_reg[1:0], b_reg[31:2]};
                b_next = a_reg;
                a_next = t_sum;
                round_next = round_reg + 7'd1;
                if (round_reg == LAST_RND)
                begin
                    state_next = ST_WB;
                    cnt_next   = '0;
                end
            end

            // Add the working registers into the chaining value
            ST_WB:
            begin
                chain_rd_en = (cnt_reg < 3'(DIGEST_N));
                if (cnt_reg != 3'd0)
                begin
                    chain_wr_en = 1'b1;
                    a_next = b_reg;
                    b_next = c_reg;
                    c_next = d_reg;
                    d_next = e_reg;
                end
                if (cnt_reg == 3'(DIGEST_N))
                begin
                    fresh_next = 1'b0;
                    cnt_next   = '0;
                    unique case (post_reg)
                        POST_IDLE:   state_next = ST_IDLE;
                        POST_PAD:    state_next = ST_PADF;
                        POST_EXTRA:
                        begin
                            state_next     = ST_PADW;
                            widx_next      = '0;
                            len_phase_next = 1'b1;
                        end
                        POST_DIGEST: state_next = ST_DRD;
                        default:     state_next = ST_IDLE;
                    endcase
                end
                else
                begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end

            ST_DRD:
            begin
                chain_rd_en = 1'b1;
                state_next  = ST_DWAIT;
                cnt_next    = cnt_reg + 3'd1;
            end

            // Hand the word to the output register once it is free
            ST_DWAIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = chain_rd;
                    out_idx_next   = cnt_prev;
                    out_final_next = (cnt_prev == LAST_IDX);
                    if (cnt_prev == LAST_IDX)
                    begin
                        state_next    = ST_IDLE;
                        fresh_next    = 1'b1;
                        byte_pos_next = '0;
                        len_next      = '0;
                    end
                    else
                    begin
                        state_next = ST_DRD;
                        cnt_next   = cnt_prev + 3'd1;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            round_reg     <= '0;
            post_reg      <= POST_IDLE;
            fresh_reg     <= 1'b1;
            byte_pos_reg  <= '0;
            len_reg       <= '0;
            widx_reg      <= '0;
            len_phase_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            round_reg     <= round_next;
            post_reg      <= post_next;
            fresh_reg     <= fresh_next;
            byte_pos_reg  <= byte_pos_next;
            len_reg       <= len_next;
            widx_reg      <= widx_next;
            len_phase_reg <= len_phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        acc_reg       <= acc_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        c_reg         <= c_next;
        d_reg         <= d_next;
        e_reg         <= e_next;
        out_word_reg  <= out_word_next;
        out_idx_reg   <= out_idx_next;
        out_final_reg <= out_final_next;
        for (int i = 0; i < BLOCK_N; i++)
        begin
            win_reg[i] <= win_next[i];
        end
    end

    assign digest.valid       = out_valid_reg;
    assign digest.digest_word = out_word_reg;
    assign digest.word_index  = out_idx_reg;
    assign digest.final_word  = out_final_reg;

    // Checks
    a_final_matches_index: assert property (@(posedge clk) disable iff (!rst_n)
        digest.valid |-> (digest.final_word == (digest.word_index == LAST_IDX)))
        else $error("final_word does not match word_index");

    a_block_full_starts_load: assert property (@(posedge clk) disable iff (!rst_n)
        (msg_fire && msg.has_byte && byte_pos_reg == 6'd63) |=> (state_reg == ST_LOAD))
        else $error("full block did not start a compression");

    a_fresh_clears_message: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(fresh_reg) |-> (byte_pos_reg == 6'd0 && len_reg == 64'd0))
        else $error("chaining value reset without clearing message state");

    a_no_chain_write_in_rounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> !chain_wr_en)
        else $error("chaining value written during rounds");

endmodule

@@ hdl/sha1b_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module sha1b_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port, holds its data while rd_en is low
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
